@@ rtl/core/pctd_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pctd_pkg: shared types and constants of the prefix code tree decoder
// Node layout, status codes, input modes and the walker state encoding.
// ----------------------------------------------------------------------------
package pctd_pkg;

    localparam int MAX_NODES    = 512;
    localparam int MAX_CODE_LEN = 32;

    localparam int NODE_W = $clog2(MAX_NODES);
    localparam int USED_W = $clog2(MAX_NODES + 1);
    localparam int CSR_W  = MAX_CODE_LEN;
    localparam int CLW    = $clog2(MAX_CODE_LEN + 1);

    localparam int SYM_W  = 8;
    localparam int LEN_W  = 6;
    localparam int CODE_W = 32;
    localparam int BYTE_W = 8;
    localparam int CNT_W  = 4;
    localparam int DBW    = $clog2(BYTE_W + 1);

    localparam int S_TDATA_W = 64;
    localparam int S_TUSER_W = 2;
    localparam int M_TDATA_W = 8;
    localparam int M_TUSER_W = 2;

    // input item kinds
    localparam logic [1:0] MODE_LOAD   = 2'd0;
    localparam logic [1:0] MODE_DECODE = 2'd1;
    localparam logic [1:0] MODE_CLEAR  = 2'd2;

    typedef enum logic [1:0] {
        ST_SYMBOL     = 2'd0,
        ST_NO_CHILD   = 2'd1,
        ST_FULL       = 2'd2,
        ST_INCOMPLETE = 2'd3
    } t_status;

    typedef struct packed {
        logic [NODE_W-1:0] left;
        logic [NODE_W-1:0] right;
        logic [SYM_W-1:0]  sym;
    } t_node;

    typedef struct packed {
        logic              we;
        logic [NODE_W-1:0] waddr;
        t_node             wdata;
        logic              re;
        logic [NODE_W-1:0] raddr;
    } t_ram_req;

    typedef struct packed {
        logic             emit;
        logic             flush;
        logic [SYM_W-1:0] sym;
        t_status          status;
    } t_res_req;

    typedef struct packed {
        logic ok;
        logic pend_v;
    } t_res_ack;

    typedef enum logic [3:0] {
        S_IDLE,
        S_LD_ALIGN,
        S_LD_STEP,
        S_LD_WAIT,
        S_LD_DONE,
        S_DEC_FETCH,
        S_DEC_STEP,
        S_DEC_CHECK,
        S_DEC_END,
        S_FLUSH
    } t_state;

endpackage

@@ rtl/core/prefix_code_tree_decoder.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// prefix_code_tree_decoder: Huffman decoder with a loadable code tree
// Builds the tree from load items, decodes stream bytes bit by bit.
// ----------------------------------------------------------------------------
// One item is worked at a time; the input stalls until the item's results
// have left the hold stage. Every item spends its accept cycle in idle. A load
// then lines up its code in the shift register (one shift per unused upper
// bit, then a check that the count has run out). Each code bit then either
// allocates a node or follows an existing link, waiting on the store read;
// then the load closes. A decode that resumes a partial code first refetches
// its node, then works each valid bit by issuing a node read and then
// checking for a leaf, then closes. Clear and unused modes end in their
// accept cycle.
// Output back-pressure adds stall cycles. After reset the root is empty and
// the block is ready at once; no clearing pass runs over the node store.
// Results: symbol in tdata, status in tuser (0 symbol, 1 missing child,
// 2 node store full, 3 code cut off at stream end), tlast on the last result
// an item causes. Loads and clears that succeed give no result.
// ----------------------------------------------------------------------------
module prefix_code_tree_decoder (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_s_axis_tvalid,
    output logic                           o_s_axis_tready,
    // [7:0] symbol_in, [13:8] code_length, [45:14] code_value,
    // [53:46] data_byte, [57:54] bit_count, [63:58] zero
    input  logic [pctd_pkg::S_TDATA_W-1:0] i_s_axis_tdata,
    input  logic [pctd_pkg::S_TUSER_W-1:0] i_s_axis_tuser,  // [1:0] mode
    input  logic                           i_s_axis_tlast,  // stream_end
    output logic                           o_m_axis_tvalid,
    input  logic                           i_m_axis_tready,
    output logic [pctd_pkg::M_TDATA_W-1:0] o_m_axis_tdata,  // [7:0] symbol_out
    output logic [pctd_pkg::M_TUSER_W-1:0] o_m_axis_tuser,  // [1:0] status
    output logic                           o_m_axis_tlast   // run_last
);
    import pctd_pkg::*;

    t_ram_req ram_req;
    t_node    rd_data;
    t_res_req res_req;
    t_res_ack res_ack;

    // node store, root kept in the walker's flip-flops
    pctd_node_ram u_ram (
        .i_clk     (i_clk),
        .i_req     (ram_req),
        .o_rd_data (rd_data)
    );

    // bit-serial walker and control
    pctd_walker u_walker (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .i_s_axis_tuser  (i_s_axis_tuser),
        .i_s_axis_tlast  (i_s_axis_tlast),
        .o_ram_req       (ram_req),
        .i_rd_data       (rd_data),
        .o_res_req       (res_req),
        .i_res_ack       (res_ack)
    );

    // one result held back so tlast is known, then the output register
    pctd_result_q u_res (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_req           (res_req),
        .o_ack           (res_ack),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata),
        .o_m_axis_tuser  (o_m_axis_tuser),
        .o_m_axis_tlast  (o_m_axis_tlast)
    );

    // error results carry a zero symbol
    a_err_sym_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && o_m_axis_tuser != ST_SYMBOL |-> o_m_axis_tdata == '0)
        else $error("error result with nonzero symbol");

    // no result is left in the hold stage between items
    a_idle_no_pend: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_s_axis_tready |-> !res_ack.pend_v)
        else $error("result held while idle");

    // a clear leaves the block ready again in the next cycle
    a_clear_quick: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_s_axis_tvalid && o_s_axis_tready && i_s_axis_tuser == MODE_CLEAR
        |=> o_s_axis_tready)
        else $error("clear did not return to idle");

    // store is never written while the block is idle
    a_idle_no_write: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_s_axis_tready |-> !ram_req.we)
        else $error("node store written while idle");

endmodule

@@ rtl/core/pctd_node_ram.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pctd_node_ram: node store of the code tree
// One write port, one read port, registered read data held until next read.
// ----------------------------------------------------------------------------
module pctd_node_ram (
    input  logic              i_clk,
    input  pctd_pkg::t_ram_req i_req,
    output pctd_pkg::t_node    o_rd_data
);
    import pctd_pkg::*;

    t_node r_mem [MAX_NODES];
    t_node r_rd;

    always_ff @(posedge i_clk) begin
        if (i_req.we) begin
            r_mem[i_req.waddr] <= i_req.wdata;
        end
        if (i_req.re) begin
            r_rd <= r_mem[i_req.raddr];
        end
    end

    assign o_rd_data = r_rd;

endmodule

@@ rtl/core/pctd_result_q.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pctd_result_q: result hold stage and output register
// Holds the newest result until the next one or the item end decides tlast.
// ----------------------------------------------------------------------------
module pctd_result_q (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  pctd_pkg::t_res_req                  i_req,
    output pctd_pkg::t_res_ack                  o_ack,
    output logic                                o_m_axis_tvalid,
    input  logic                                i_m_axis_tready,
    output logic [pctd_pkg::M_TDATA_W-1:0]      o_m_axis_tdata,  // [7:0] symbol_out
    output logic [pctd_pkg::M_TUSER_W-1:0]      o_m_axis_tuser,  // [1:0] status
    output logic                                o_m_axis_tlast   // run_last
);
    import pctd_pkg::*;

    logic             r_pend_v, n_pend_v;
    logic [SYM_W-1:0] r_pend_sym, n_pend_sym;
    t_status          r_pend_st, n_pend_st;
    logic             r_out_v, n_out_v;
    logic [SYM_W-1:0] r_out_sym, n_out_sym;
    t_status          r_out_st, n_out_st;
    logic             r_out_last, n_out_last;
    logic             out_free;
    logic             ok;

    assign out_free = !r_out_v || i_m_axis_tready;
    assign ok       = !r_pend_v || out_free;

    always_comb begin
        n_pend_v   = r_pend_v;
        n_pend_sym = r_pend_sym;
        n_pend_st  = r_pend_st;
        n_out_v    = r_out_v && !i_m_axis_tready;
        n_out_sym  = r_out_sym;
        n_out_st   = r_out_st;
        n_out_last = r_out_last;
        if (i_req.emit && ok) begin
            if (r_pend_v) begin
                n_out_v    = 1'b1;
                n_out_sym  = r_pend_sym;
                n_out_st   = r_pend_st;
                n_out_last = 1'b0;
            end
            n_pend_v   = 1'b1;
            n_pend_sym = i_req.sym;
            n_pend_st  = i_req.status;
        end else if (i_req.flush && ok) begin
            if (r_pend_v) begin
                n_out_v    = 1'b1;
                n_out_sym  = r_pend_sym;
                n_out_st   = r_pend_st;
                n_out_last = 1'b1;
            end
            n_pend_v = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pend_v <= 1'b0;
            r_out_v  <= 1'b0;
        end else begin
            r_pend_v <= n_pend_v;
            r_out_v  <= n_out_v;
        end
        r_pend_sym <= n_pend_sym;
        r_pend_st  <= n_pend_st;
        r_out_sym  <= n_out_sym;
        r_out_st   <= n_out_st;
        r_out_last <= n_out_last;
    end

    assign o_ack.ok         = ok;
    assign o_ack.pend_v     = r_pend_v;
    assign o_m_axis_tvalid  = r_out_v;
    assign o_m_axis_tdata   = r_out_sym;
    assign o_m_axis_tuser   = r_out_st;
    assign o_m_axis_tlast   = r_out_last;

endmodule

@@ rtl/core/pctd_walker.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pctd_walker: bit-serial tree walker
// Shifts code and data bits out one at a time, follows child links through
// the node store, allocates nodes on load and raises results on decode.
// ----------------------------------------------------------------------------
module pctd_walker (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_s_axis_tvalid,
    output logic                           o_s_axis_tready,
    input  logic [pctd_pkg::S_TDATA_W-1:0] i_s_axis_tdata,
    input  logic [pctd_pkg::S_TUSER_W-1:0] i_s_axis_tuser,
    input  logic                           i_s_axis_tlast,
    output pctd_pkg::t_ram_req             o_ram_req,
    input  pctd_pkg::t_node                i_rd_data,
    output pctd_pkg::t_res_req             o_res_req,
    input  pctd_pkg::t_res_ack             i_res_ack
);
    import pctd_pkg::*;

    t_state            r_state, n_state;
    logic [CSR_W-1:0]  r_code, n_code;
    logic [CLW-1:0]    r_acnt, n_acnt;
    logic [CLW-1:0]    r_bits, n_bits;
    logic [BYTE_W-1:0] r_dbyte, n_dbyte;
    logic [DBW-1:0]    r_dbits, n_dbits;
    logic              r_end, n_end;
    logic [SYM_W-1:0]  r_sym, n_sym;
    logic [NODE_W-1:0] r_node, n_node;
    logic [NODE_W-1:0] r_cur, n_cur;
    t_node             r_ent, n_ent;
    logic [NODE_W-1:0] r_root_l, n_root_l;
    logic [NODE_W-1:0] r_root_r, n_root_r;
    logic [USED_W-1:0] r_used, n_used;

    // input fields
    logic [SYM_W-1:0]  in_sym;
    logic [LEN_W-1:0]  in_len;
    logic [CODE_W-1:0] in_code;
    logic [BYTE_W-1:0] in_byte;
    logic [CNT_W-1:0]  in_cnt;
    logic [CLW-1:0]    len_sat;
    logic [DBW-1:0]    cnt_sat;

    t_node             root_ent;
    t_node             upd_ent;
    logic              ld_bit, dec_bit, bit_v;
    logic [NODE_W-1:0] child;
    logic [NODE_W-1:0] new_idx;
    logic              full;

    assign in_sym  = i_s_axis_tdata[7:0];
    assign in_len  = i_s_axis_tdata[13:8];
    assign in_code = i_s_axis_tdata[45:14];
    assign in_byte = i_s_axis_tdata[53:46];
    assign in_cnt  = i_s_axis_tdata[57:54];

    assign len_sat = (in_len > LEN_W'(MAX_CODE_LEN)) ? CLW'(MAX_CODE_LEN) : CLW'(in_len);
    assign cnt_sat = (in_cnt > CNT_W'(BYTE_W)) ? DBW'(BYTE_W) : DBW'(in_cnt);

    assign root_ent = '{left: r_root_l, right: r_root_r, sym: '0};
    assign ld_bit   = r_code[CSR_W-1];
    assign dec_bit  = r_dbyte[BYTE_W-1];
    assign bit_v    = (r_state == S_LD_STEP) ? ld_bit : dec_bit;
    assign child    = bit_v ? r_ent.right : r_ent.left;
    assign new_idx  = r_used[NODE_W-1:0];
    assign full     = (r_used >= USED_W'(MAX_NODES));

    always_comb begin
        upd_ent = r_ent;
        if (ld_bit) begin
            upd_ent.right = new_idx;
        end else begin
            upd_ent.left = new_idx;
        end
    end

    always_comb begin
        n_state  = r_state;
        n_code   = r_code;
        n_acnt   = r_acnt;
        n_bits   = r_bits;
        n_dbyte  = r_dbyte;
        n_dbits  = r_dbits;
        n_end    = r_end;
        n_sym    = r_sym;
        n_node   = r_node;
        n_cur    = r_cur;
        n_ent    = r_ent;
        n_root_l = r_root_l;
        n_root_r = r_root_r;
        n_used   = r_used;
        o_ram_req = '0;
        o_res_req = '0;

        unique case (r_state)
            S_IDLE: begin
                if (i_s_axis_tvalid) begin
                    unique case (i_s_axis_tuser)
                        MODE_LOAD: begin
                            n_code  = CSR_W'(in_code);
                            n_bits  = len_sat;
                            n_acnt  = CLW'(MAX_CODE_LEN) - len_sat;
                            n_sym   = in_sym;
                            n_node  = '0;
                            n_ent   = root_ent;
                            n_state = S_LD_ALIGN;
                        end
                        MODE_DECODE: begin
                            n_dbyte = in_byte;
                            n_dbits = cnt_sat;
                            n_end   = i_s_axis_tlast;
                            if (r_cur == '0) begin
                                n_ent   = root_ent;
                                n_state = S_DEC_STEP;
                            end else begin
                                o_ram_req.re    = 1'b1;
                                o_ram_req.raddr = r_cur;
                                n_state         = S_DEC_FETCH;
                            end
                        end
                        MODE_CLEAR: begin
                            n_root_l = '0;
                            n_root_r = '0;
                            n_used   = USED_W'(1);
                            n_cur    = '0;
                        end
                        default: ;
                    endcase
                end
            end
            // drop the unused upper code bits, one per cycle
            S_LD_ALIGN: begin
                if (r_acnt == '0) begin
                    n_state = S_LD_STEP;
                end else begin
                    n_code = r_code << 1;
                    n_acnt = r_acnt - CLW'(1);
                end
            end
            S_LD_STEP: begin
                if (r_bits == '0) begin
                    n_state = S_LD_DONE;
                end else if (child != '0) begin
                    o_ram_req.re    = 1'b1;
                    o_ram_req.raddr = child;
                    n_node          = child;
                    n_code          = r_code << 1;
                    n_bits          = r_bits - CLW'(1);
                    n_state         = S_LD_WAIT;
                end else if (full) begin
                    o_res_req.emit   = 1'b1;
                    o_res_req.status = ST_FULL;
                    if (i_res_ack.ok) begin
                        // last allocated node must reach the store
                        o_ram_req.we    = (r_node != '0);
                        o_ram_req.waddr = r_node;
                        o_ram_req.wdata = r_ent;
                        n_state         = S_FLUSH;
                    end
                end else begin
                    // allocate: link parent now, new node is written later
                    if (r_node == '0) begin
                        n_root_l = upd_ent.left;
                        n_root_r = upd_ent.right;
                    end else begin
                        o_ram_req.we    = 1'b1;
                        o_ram_req.waddr = r_node;
                        o_ram_req.wdata = upd_ent;
                    end
                    n_ent  = '0;
                    n_node = new_idx;
                    n_used = r_used + USED_W'(1);
                    n_code = r_code << 1;
                    n_bits = r_bits - CLW'(1);
                end
            end
            S_LD_WAIT: begin
                n_ent   = i_rd_data;
                n_state = S_LD_STEP;
            end
            S_LD_DONE: begin
                o_ram_req.we    = (r_node != '0);
                o_ram_req.waddr = r_node;
                o_ram_req.wdata = '{left: r_ent.left, right: r_ent.right, sym: r_sym};
                n_state         = S_FLUSH;
            end
            S_DEC_FETCH: begin
                n_ent   = i_rd_data;
                n_state = S_DEC_STEP;
            end
            S_DEC_STEP: begin
                if (r_dbits == '0) begin
                    n_state = S_DEC_END;
                end else if (child == '0) begin
                    o_res_req.emit   = 1'b1;
                    o_res_req.status = ST_NO_CHILD;
                    if (i_res_ack.ok) begin
                        n_cur   = '0;
                        n_state = S_FLUSH;
                    end
                end else begin
                    o_ram_req.re    = 1'b1;
                    o_ram_req.raddr = child;
                    n_cur           = child;
                    n_dbyte         = r_dbyte << 1;
                    n_dbits         = r_dbits - DBW'(1);
                    n_state         = S_DEC_CHECK;
                end
            end
            S_DEC_CHECK: begin
                if (i_rd_data.left == '0 && i_rd_data.right == '0) begin
                    o_res_req.emit   = 1'b1;
                    o_res_req.sym    = i_rd_data.sym;
                    o_res_req.status = ST_SYMBOL;
                    if (i_res_ack.ok) begin
                        n_cur   = '0;
                        n_ent   = root_ent;
                        n_state = S_DEC_STEP;
                    end
                end else begin
                    n_ent   = i_rd_data;
                    n_state = S_DEC_STEP;
                end
            end
            S_DEC_END: begin
                if (r_end && r_cur != '0) begin
                    o_res_req.emit   = 1'b1;
                    o_res_req.status = ST_INCOMPLETE;
                    if (i_res_ack.ok) begin
                        n_cur   = '0;
                        n_state = S_FLUSH;
                    end
                end else begin
                    n_state = S_FLUSH;
                end
            end
            S_FLUSH: begin
                o_res_req.flush = 1'b1;
                if (i_res_ack.ok) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_root_l <= '0;
            r_root_r <= '0;
            r_used   <= USED_W'(1);
            r_cur    <= '0;
        end else begin
            r_state  <= n_state;
            r_root_l <= n_root_l;
            r_root_r <= n_root_r;
            r_used   <= n_used;
            r_cur    <= n_cur;
        end
        r_code  <= n_code;
        r_acnt  <= n_acnt;
        r_bits  <= n_bits;
        r_dbyte <= n_dbyte;
        r_dbits <= n_dbits;
        r_end   <= n_end;
        r_sym   <= n_sym;
        r_node  <= n_node;
        r_ent   <= n_ent;
    end

    assign o_s_axis_tready = (r_state == S_IDLE);

endmodule

@@ dv/pctd_tree_checker.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pctd_tree_checker: result checker for the prefix code tree decoder
// Keeps its own copy of the code tree, works out the results of every
// accepted input item and compares each accepted result against them.
// ----------------------------------------------------------------------------
module pctd_tree_checker (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_s_tvalid,
    input  logic                           i_s_tready,
    input  logic [pctd_pkg::S_TDATA_W-1:0] i_s_tdata,
    input  logic [pctd_pkg::S_TUSER_W-1:0] i_s_tuser,
    input  logic                           i_s_tlast,
    input  logic                           i_m_tvalid,
    input  logic                           i_m_tready,
    input  logic [pctd_pkg::M_TDATA_W-1:0] i_m_tdata,
    input  logic [pctd_pkg::M_TUSER_W-1:0] i_m_tuser,
    input  logic                           i_m_tlast,
    output int                             o_mismatches,
    output int                             o_pending,
    output int                             o_results,
    output int                             o_symbols,
    output int                             o_no_child,
    output int                             o_full,
    output int                             o_cut_off
);
    import pctd_pkg::*;

    localparam int ERR_SHOWN = 40;

    // input tdata, highest field first
    typedef struct packed {
        logic [5:0]        pad;
        logic [CNT_W-1:0]  bit_cnt;
        logic [BYTE_W-1:0] data_byte;
        logic [CODE_W-1:0] code_bits;
        logic [LEN_W-1:0]  code_len;
        logic [SYM_W-1:0]  sym_in;
    } t_in_word;

    typedef struct packed {
        logic [SYM_W-1:0] sym;
        t_status          status;
        logic             last;
    } t_decoded;

    logic [NODE_W-1:0] left_link  [MAX_NODES];
    logic [NODE_W-1:0] right_link [MAX_NODES];
    logic [SYM_W-1:0]  node_sym   [MAX_NODES];
    int unsigned       nodes_taken;
    logic [NODE_W-1:0] walk_pos;

    t_decoded due_symbols[$];
    t_decoded batch[$];

    function automatic void wipe_tree();
        for (int k = 0; k < MAX_NODES; k++) begin
            left_link[k]  = '0;
            right_link[k] = '0;
            node_sym[k]   = '0;
        end
        nodes_taken = 1;
        walk_pos    = '0;
    endfunction

    function automatic void emit_result(logic [SYM_W-1:0] s, t_status st);
        t_decoded r;
        r.sym    = s;
        r.status = st;
        r.last   = 1'b0;
        batch.push_back(r);
    endfunction

    // walk the code MSB first, allocating nodes; a full store stops the load
    function automatic void insert_code(t_in_word w);
        int unsigned       len;
        logic [NODE_W-1:0] node;
        logic [NODE_W-1:0] child;
        logic              bit_v;
        len  = (w.code_len > MAX_CODE_LEN) ? MAX_CODE_LEN : w.code_len;
        node = '0;
        for (int i = len; i > 0; i--) begin
            bit_v = w.code_bits[i-1];
            child = bit_v ? right_link[node] : left_link[node];
            if (child == '0) begin
                if (nodes_taken >= MAX_NODES) begin
                    emit_result('0, ST_FULL);
                    return;
                end
                child = nodes_taken[NODE_W-1:0];
                nodes_taken++;
                left_link[child]  = '0;
                right_link[child] = '0;
                node_sym[child]   = '0;
                if (bit_v)
                    right_link[node] = child;
                else
                    left_link[node] = child;
            end
            node = child;
        end
        node_sym[node] = w.sym_in;
    endfunction

    // walk the leading bits of a stream byte from where the last one stopped
    function automatic void walk_byte(t_in_word w, logic at_end);
        int unsigned       cnt;
        logic [NODE_W-1:0] child;
        cnt = (w.bit_cnt > BYTE_W) ? BYTE_W : w.bit_cnt;
        for (int j = 0; j < cnt; j++) begin
            child = w.data_byte[7-j] ? right_link[walk_pos] : left_link[walk_pos];
            if (child == '0) begin
                emit_result('0, ST_NO_CHILD);
                walk_pos = '0;
                return;
            end
            walk_pos = child;
            if (left_link[child] == '0 && right_link[child] == '0) begin
                emit_result(node_sym[child], ST_SYMBOL);
                walk_pos = '0;
            end
        end
        if (at_end && walk_pos != '0) begin
            emit_result('0, ST_INCOMPLETE);
            walk_pos = '0;
        end
    endfunction

    function automatic void predict_item(logic [1:0] mode, t_in_word w, logic at_end);
        t_decoded r;
        batch.delete();
        case (mode)
            MODE_LOAD:   insert_code(w);
            MODE_DECODE: walk_byte(w, at_end);
            MODE_CLEAR:  wipe_tree();
            default: ;
        endcase
        foreach (batch[k]) begin
            r      = batch[k];
            r.last = (k == batch.size() - 1);
            due_symbols.push_back(r);
        end
    endfunction

    always @(posedge i_clk) begin : track
        t_decoded want;
        if (!i_rst_n) begin
            wipe_tree();
            due_symbols.delete();
            o_mismatches = 0;
            o_results    = 0;
            o_symbols    = 0;
            o_no_child   = 0;
            o_full       = 0;
            o_cut_off    = 0;
        end else begin
            // input first: a result can never leave in the cycle its item enters
            if (i_s_tvalid && i_s_tready)
                predict_item(i_s_tuser, t_in_word'(i_s_tdata), i_s_tlast);
            if (i_m_tvalid && i_m_tready) begin
                o_results++;
                case (t_status'(i_m_tuser))
                    ST_SYMBOL:   o_symbols++;
                    ST_NO_CHILD: o_no_child++;
                    ST_FULL:     o_full++;
                    default:     o_cut_off++;
                endcase
                if (due_symbols.size() == 0) begin
                    o_mismatches++;
                    if (o_mismatches <= ERR_SHOWN)
                        $error("unexpected result: symbol_out %0d, status %0d, run_last %0d",
                               i_m_tdata, i_m_tuser, i_m_tlast);
                end else begin
                    want = due_symbols.pop_front();
                    if (i_m_tdata !== want.sym) begin
                        o_mismatches++;
                        if (o_mismatches <= ERR_SHOWN)
                            $error("symbol_out: expected %0d, got %0d", want.sym, i_m_tdata);
                    end
                    if (i_m_tuser !== want.status) begin
                        o_mismatches++;
                        if (o_mismatches <= ERR_SHOWN)
                            $error("status: expected %0d, got %0d", want.status, i_m_tuser);
                    end
                    if (i_m_tlast !== want.last) begin
                        o_mismatches++;
                        if (o_mismatches <= ERR_SHOWN)
                            $error("run_last: expected %0d, got %0d", want.last, i_m_tlast);
                    end
                end
            end
        end
        o_pending = due_symbols.size();
    end

endmodule

@@ dv/tb_top.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top: stimulus and verdict for the prefix code tree decoder
// Loads random prefix codes, decodes random stream bytes through them, and
// fills the node store to its limit, with random gaps and back-pressure.
// Checking is done by pctd_tree_checker beside the block.
// ----------------------------------------------------------------------------
module tb_top;
    import pctd_pkg::*;

    // the block ignores this mode; named here for the noise items
    localparam logic [1:0] MODE_UNUSED = 2'd3;

    localparam int TARGET_ITEMS = 370;
    // limit for the watchdog over the whole run
    localparam int CYCLE_LIMIT  = 1_000_000;
    // wait after the last due result, to catch stray results
    localparam int DRAIN_CYCLES = 150;

    logic                 clk   = 1'b0;
    logic                 rst_n = 1'b0;

    logic                 s_tvalid = 1'b0;
    logic                 s_tready;
    // [7:0] symbol_in, [13:8] code_length, [45:14] code_value,
    // [53:46] data_byte, [57:54] bit_count, [63:58] zero
    logic [S_TDATA_W-1:0] s_tdata  = '0;
    logic [S_TUSER_W-1:0] s_tuser  = MODE_CLEAR;  // [1:0] mode
    logic                 s_tlast  = 1'b0;        // stream_end
    logic                 m_tvalid;
    logic                 m_tready = 1'b0;
    logic [M_TDATA_W-1:0] m_tdata;                // [7:0] symbol_out
    logic [M_TUSER_W-1:0] m_tuser;                // [1:0] status
    logic                 m_tlast;                // run_last

    int mismatches, pending, results, symbols, no_child, full_hits, cut_off;

    // no gaps and no back-pressure while set
    bit steady = 1'b0;

    int n_items  = 0;
    int n_load   = 0;
    int n_decode = 0;
    int n_clear  = 0;
    int n_unused = 0;
    int cycles   = 0;
    int hold_left = 0;

    // codes of the current tree, right aligned
    int unsigned leaf_code[$];
    int unsigned leaf_len[$];

    prefix_code_tree_decoder uut (
        .i_clk           (clk),
        .i_rst_n         (rst_n),
        .i_s_axis_tvalid (s_tvalid),
        .o_s_axis_tready (s_tready),
        .i_s_axis_tdata  (s_tdata),
        .i_s_axis_tuser  (s_tuser),
        .i_s_axis_tlast  (s_tlast),
        .o_m_axis_tvalid (m_tvalid),
        .i_m_axis_tready (m_tready),
        .o_m_axis_tdata  (m_tdata),
        .o_m_axis_tuser  (m_tuser),
        .o_m_axis_tlast  (m_tlast)
    );

    pctd_tree_checker tree_check (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .i_s_tvalid   (s_tvalid),
        .i_s_tready   (s_tready),
        .i_s_tdata    (s_tdata),
        .i_s_tuser    (s_tuser),
        .i_s_tlast    (s_tlast),
        .i_m_tvalid   (m_tvalid),
        .i_m_tready   (m_tready),
        .i_m_tdata    (m_tdata),
        .i_m_tuser    (m_tuser),
        .i_m_tlast    (m_tlast),
        .o_mismatches (mismatches),
        .o_pending    (pending),
        .o_results    (results),
        .o_symbols    (symbols),
        .o_no_child   (no_child),
        .o_full       (full_hits),
        .o_cut_off    (cut_off)
    );

    initial begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // watchdog
    always @(posedge clk) begin
        cycles++;
        if (cycles >= CYCLE_LIMIT) begin
            $display("Timeout after %0d cycles, %0d results still due", cycles, pending);
            $display("Mismatches found");
            $finish;
        end
    end

    // result side back-pressure: runs of ready, mostly short stalls, a few long
    always @(posedge clk) begin : sink_pace
        int r;
        if (steady) begin
            m_tready  <= 1'b1;
            hold_left = 0;
        end else if (hold_left > 0) begin
            hold_left--;
        end else begin
            r = $urandom_range(99);
            if (r < 55) begin
                m_tready  <= 1'b1;
                hold_left = $urandom_range(11, 0);
            end else if (r < 90) begin
                m_tready  <= 1'b0;
                hold_left = $urandom_range(2, 0);
            end else if (r < 97) begin
                m_tready  <= 1'b0;
                hold_left = $urandom_range(9, 3);
            end else begin
                m_tready  <= 1'b0;
                hold_left = $urandom_range(39, 14);
            end
        end
    end

    function automatic int pick_gap();
        int r;
        if (steady)
            return 0;
        r = $urandom_range(99);
        if (r < 55)
            return 0;
        if (r < 88)
            return $urandom_range(3, 1);
        if (r < 97)
            return $urandom_range(10, 4);
        return $urandom_range(60, 20);
    endfunction

    // one item: optional gap, then hold valid until the block takes it
    task automatic send_item(input logic [1:0] mode, input logic [7:0] sym,
                             input logic [5:0] len, input logic [31:0] code,
                             input logic [7:0] dbyte, input logic [3:0] cnt,
                             input logic at_end);
        int gap;
        gap = pick_gap();
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= mode;
        s_tdata  <= {6'b0, cnt, dbyte, code, len, sym};
        s_tlast  <= at_end;
        do @(posedge clk); while (!s_tready);
        case (mode)
            MODE_LOAD:   n_load++;
            MODE_DECODE: n_decode++;
            MODE_CLEAR:  n_clear++;
            default:     n_unused++;
        endcase
        if (mode != MODE_UNUSED)
            n_items++;
    endtask

    // fields that an item kind does not use still carry random bits
    task automatic send_load(input logic [7:0] sym, input logic [5:0] len,
                             input logic [31:0] code);
        send_item(MODE_LOAD, sym, len, code, 8'($urandom_range(255)),
                  4'($urandom_range(15)), 1'($urandom_range(1)));
    endtask

    task automatic send_decode(input logic [7:0] dbyte, input logic [3:0] cnt,
                               input logic at_end);
        send_item(MODE_DECODE, 8'($urandom_range(255)), 6'($urandom_range(63)), $urandom,
                  dbyte, cnt, at_end);
    endtask

    task automatic send_clear();
        send_item(MODE_CLEAR, 8'($urandom_range(255)), 6'($urandom_range(63)), $urandom,
                  8'($urandom_range(255)), 4'($urandom_range(15)), 1'($urandom_range(1)));
    endtask

    task automatic send_unused();
        send_item(MODE_UNUSED, 8'($urandom_range(255)), 6'($urandom_range(63)), $urandom,
                  8'($urandom_range(255)), 4'($urandom_range(15)), 1'($urandom_range(1)));
    endtask

    // complete prefix code: split random leaves, none past depth, until the count or 200 tries
    function automatic void grow_code_set(int leaves, int depth);
        int          idx;
        int          tries;
        int unsigned c;
        int unsigned l;
        leaf_code.delete();
        leaf_len.delete();
        leaf_code.push_back(0);
        leaf_len.push_back(0);
        tries = 0;
        while (leaf_code.size() < leaves && tries < 200) begin
            idx = $urandom_range(leaf_code.size() - 1);
            if (leaf_len[idx] < depth) begin
                c = leaf_code[idx];
                l = leaf_len[idx];
                leaf_code[idx] = c << 1;
                leaf_len[idx]  = l + 1;
                leaf_code.push_back((c << 1) | 1);
                leaf_len.push_back(l + 1);
            end
            tries++;
        end
    endfunction

    initial begin : stimulus
        int session;
        int kind;
        int idx;
        int nbytes;
        int r;
        logic [3:0] cnt;
        logic       at_end;

        rst_n <= 1'b0;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;

        // ---- directed ----
        // empty tree: first bit already has no child
        send_decode(8'hA5, 4'd8, 1'b0);
        // one-bit codes: every bit of a byte is a symbol, eight results
        send_load(8'h11, 6'd1, 32'h0);
        send_load(8'hEE, 6'd1, 32'h1);
        send_decode(8'h55, 4'd8, 1'b1);
        // bit count above eight saturates, zero walks nothing
        send_decode(8'hFF, 4'd15, 1'b0);
        send_decode(8'h00, 4'd0, 1'b1);
        send_clear();
        // longest code, all ones, and symbol extremes
        send_load(8'hFF, 6'd32, 32'hFFFF_FFFF);
        send_load(8'h00, 6'd3, 32'h0);
        // empty code lands on the root, never emitted
        send_load(8'h5A, 6'd0, $urandom);
        // oversize length clamps to 32 bits
        send_load(8'h81, 6'd63, 32'h8000_0001);
        // two symbols, then a partial code cut off at stream end
        send_decode(8'h00, 4'd8, 1'b1);
        // "001" runs off the tree
        send_decode(8'h20, 4'd3, 1'b0);
        // longer code through the leaf "000" turns it into an inner node
        send_load(8'h33, 6'd4, 32'h0);
        send_decode(8'h00, 4'd8, 1'b0);
        // walk position survives a load between two stream bytes
        send_decode(8'h00, 4'd2, 1'b0);
        send_load(8'h44, 6'd2, 32'h3);
        send_decode(8'h00, 4'd2, 1'b0);
        send_unused();
        // deep into the all-ones path, stream ends mid-code
        send_decode(8'hFF, 4'd8, 1'b1);
        send_decode(8'h80, 4'd1, 1'b1);
        send_clear();

        // ---- random sessions ----
        session = 0;
        while (n_items < TARGET_ITEMS) begin
            steady = ($urandom_range(3) == 0);
            // session 2 always runs the store to its limit
            kind = (session == 2) ? 0 : $urandom_range(99);
            if (kind < 8) begin
                send_clear();
                // ~31 new nodes per random 32-bit code: store full after ~17
                repeat (20) send_load(8'($urandom_range(255)), 6'd32, $urandom);
                repeat (2) send_load(8'($urandom_range(255)), 6'($urandom_range(63, 33)),
                                     $urandom);
                repeat (4) send_decode(8'($urandom_range(255)), 4'd8,
                                       1'($urandom_range(1)));
            end else begin
                if ($urandom_range(99) < 85)
                    send_clear();
                grow_code_set($urandom_range(20, 2), $urandom_range(12, 3));
                // drop a leaf now and then so some paths go nowhere
                if ($urandom_range(99) < 20 && leaf_code.size() > 2) begin
                    idx = $urandom_range(leaf_code.size() - 1);
                    leaf_code.delete(idx);
                    leaf_len.delete(idx);
                end
                while (leaf_code.size() > 0) begin
                    idx = $urandom_range(leaf_code.size() - 1);
                    send_load(8'($urandom_range(255)), 6'(leaf_len[idx]), leaf_code[idx]);
                    leaf_code.delete(idx);
                    leaf_len.delete(idx);
                end
                if ($urandom_range(99) < 10)
                    send_load(8'($urandom_range(255)), 6'($urandom_range(63)), $urandom);
                nbytes = $urandom_range(14, 2);
                for (int b = 0; b < nbytes; b++) begin
                    r = $urandom_range(99);
                    if (r < 3)
                        send_unused();
                    else if (r < 5)
                        send_clear();
                    cnt    = ($urandom_range(99) < 80) ? 4'd8 : 4'($urandom_range(15));
                    at_end = (b == nbytes - 1) ? ($urandom_range(9) != 0)
                                               : ($urandom_range(19) == 0);
                    send_decode(8'($urandom_range(255)), cnt, at_end);
                end
            end
            session++;
        end
        s_tvalid <= 1'b0;

        // drain: everything due must arrive, then watch for strays
        steady = 1'b1;
        while (pending != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("Stimulus: %0d loads, %0d decodes, %0d clears, %0d unused-mode items",
                 n_load, n_decode, n_clear, n_unused);
        $display("Results: %0d total, %0d symbols, %0d missing child, %0d store full, %0d cut off",
                 results, symbols, no_child, full_hits, cut_off);
        if (mismatches == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule
